FILE: rtl/motor_drive_linearizer_assert.svh
// assertion macros shared by the linearizer rtl
`ifndef MOTOR_DRIVE_LINEARIZER_ASSERT_SVH
`define MOTOR_DRIVE_LINEARIZER_ASSERT_SVH

// same-cycle implication, quiet during reset
`define MDL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("motor_drive_linearizer: same-cycle check failed");

// next-cycle implication, quiet during reset
`define MDL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("motor_drive_linearizer: next-cycle check failed");

`endif

FILE: rtl/mdl_pkg.sv
// constants and rounding helper for the motor drive linearizer
`default_nettype none

package mdl_pkg;

  // pipeline depth, input register to output register
  localparam int unsigned STAGES = 11;

  localparam int unsigned IN_W  = 16;
  localparam int unsigned OUT_W = 17;

  localparam logic signed [15:0] IN_DEADBAND = 16'sd2687;
  // 1/0.918 in q30
  localparam logic signed [31:0] RESCALE     = 32'sd1169653403;
  // polynomial coefficients in q28
  localparam logic signed [31:0] A1          = 32'sd105995498;
  localparam logic signed [31:0] A3          = 32'sd180836914;
  localparam logic signed [31:0] A5          = -32'sd915273368;
  localparam logic signed [31:0] A7          = 32'sd1126657163;
  // 0.425 and 0.15*0.918 in q30
  localparam logic signed [31:0] POLY_WEIGHT = 32'sd456340275;
  localparam logic signed [31:0] LINE_WEIGHT = 32'sd147854249;
  // 0.001 and 0.082 in q30
  localparam logic signed [34:0] THRESH      = 35'sd1073742;
  localparam logic signed [34:0] OUT_DEADBAND = 35'sd88046830;
  localparam logic signed [20:0] OUT_LIMIT   = 21'sd34000;

  // round half up, then arithmetic shift right by s
  function automatic logic signed [71:0] rnd(input logic signed [71:0] v,
                                             input int unsigned s);
    logic signed [71:0] half;
    half = 72'sd1 <<< (s - 1);
    return (v + half) >>> s;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mdl_datapath.sv
// data registers of the linearizer pipeline, one enable per stage
`default_nettype none

module mdl_datapath (
  input  wire logic                              clk,
  input  wire logic [mdl_pkg::STAGES-1:0]        en,
  input  wire logic signed [mdl_pkg::IN_W-1:0]   speed_request,
  output logic signed [mdl_pkg::OUT_W-1:0]       drive_value
);

  // stage 0: deadband removal
  logic signed [15:0] g_s0;
  // stage 1: rescale
  logic signed [31:0] u_s1;
  // stage 2: square
  logic signed [31:0] u_s2, sq_s2;
  // stage 3: cube, linear term, line term
  logic signed [31:0] sq_s3, cu_s3, ln_s3;
  logic signed [33:0] t1_s3;
  // stage 4: fifth power, cubic term
  logic signed [31:0] sq_s4, p5_s4, ln_s4;
  logic signed [33:0] t1_s4, t3_s4;
  // stage 5: seventh power, fifth-order term
  logic signed [31:0] p7_s5, ln_s5;
  logic signed [33:0] t1_s5, t3_s5, t5_s5;
  // stage 6: seventh-order term
  logic signed [31:0] ln_s6;
  logic signed [33:0] t1_s6, t3_s6, t5_s6, t7_s6;
  // stage 7: polynomial sum
  logic signed [31:0] ln_s7;
  logic signed [33:0] p_s7;
  // stage 8: weighted polynomial
  logic signed [31:0] ln_s8;
  logic signed [33:0] ap_s8;
  // stage 9: blend and threshold flags
  logic signed [34:0] a_s9;
  logic               pos_s9, neg_s9;
  // stage 10: output register
  logic signed [16:0] r_s10;

  logic signed [15:0] g_next;
  logic signed [47:0] m_resc;
  logic signed [63:0] m_sq, m_cu, m_t1, m_ln, m_p5, m_t3, m_p7, m_t5, m_t7, m_ap;
  logic signed [71:0] r_resc, r_sq, r_cu, r_t1, r_ln, r_p5, r_t3, r_p7, r_t5, r_t7, r_ap;
  logic signed [35:0] p_sum;
  logic signed [34:0] a_sum, a_adj;
  logic signed [71:0] r_out;
  logic signed [20:0] r_wide;
  logic signed [16:0] r_next;

  always_comb begin
    if (speed_request > mdl_pkg::IN_DEADBAND) begin
      g_next = speed_request - mdl_pkg::IN_DEADBAND;
    end else if (speed_request < -mdl_pkg::IN_DEADBAND) begin
      g_next = speed_request + mdl_pkg::IN_DEADBAND;
    end else begin
      g_next = '0;
    end
  end

  assign m_resc = g_s0 * mdl_pkg::RESCALE;
  assign r_resc = mdl_pkg::rnd(72'(m_resc), 15);

  assign m_sq = u_s1 * u_s1;
  assign r_sq = mdl_pkg::rnd(72'(m_sq), 30);

  assign m_cu = sq_s2 * u_s2;
  assign r_cu = mdl_pkg::rnd(72'(m_cu), 30);
  assign m_t1 = u_s2 * mdl_pkg::A1;
  assign r_t1 = mdl_pkg::rnd(72'(m_t1), 28);
  assign m_ln = u_s2 * mdl_pkg::LINE_WEIGHT;
  assign r_ln = mdl_pkg::rnd(72'(m_ln), 30);

  assign m_p5 = cu_s3 * sq_s3;
  assign r_p5 = mdl_pkg::rnd(72'(m_p5), 30);
  assign m_t3 = cu_s3 * mdl_pkg::A3;
  assign r_t3 = mdl_pkg::rnd(72'(m_t3), 28);

  assign m_p7 = p5_s4 * sq_s4;
  assign r_p7 = mdl_pkg::rnd(72'(m_p7), 30);
  assign m_t5 = p5_s4 * mdl_pkg::A5;
  assign r_t5 = mdl_pkg::rnd(72'(m_t5), 28);

  assign m_t7 = p7_s5 * mdl_pkg::A7;
  assign r_t7 = mdl_pkg::rnd(72'(m_t7), 28);

  // polynomial stays below two in q30 for every request
  assign p_sum = 36'(t1_s6) + 36'(t3_s6) + 36'(t5_s6) + 36'(t7_s6);

  assign m_ap = p_s7 * mdl_pkg::POLY_WEIGHT;
  assign r_ap = mdl_pkg::rnd(72'(m_ap), 30);

  assign a_sum = 35'(ap_s8) + 35'(ln_s8);

  // add the deadband back with the sign of the blend, round, clamp
  always_comb begin
    if (pos_s9) begin
      a_adj = a_s9 + mdl_pkg::OUT_DEADBAND;
    end else if (neg_s9) begin
      a_adj = a_s9 - mdl_pkg::OUT_DEADBAND;
    end else begin
      a_adj = a_s9;
    end
    r_out  = mdl_pkg::rnd(72'(a_adj), 15);
    r_wide = $signed(r_out[20:0]);
    if (r_wide > mdl_pkg::OUT_LIMIT) begin
      r_next = 17'(mdl_pkg::OUT_LIMIT);
    end else if (r_wide < -mdl_pkg::OUT_LIMIT) begin
      r_next = 17'(-mdl_pkg::OUT_LIMIT);
    end else begin
      r_next = r_wide[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      g_s0 <= g_next;
    end
    if (en[1]) begin
      u_s1 <= $signed(r_resc[31:0]);
    end
    if (en[2]) begin
      u_s2  <= u_s1;
      sq_s2 <= $signed(r_sq[31:0]);
    end
    if (en[3]) begin
      sq_s3 <= sq_s2;
      cu_s3 <= $signed(r_cu[31:0]);
      t1_s3 <= $signed(r_t1[33:0]);
      ln_s3 <= $signed(r_ln[31:0]);
    end
    if (en[4]) begin
      sq_s4 <= sq_s3;
      p5_s4 <= $signed(r_p5[31:0]);
      t1_s4 <= t1_s3;
      t3_s4 <= $signed(r_t3[33:0]);
      ln_s4 <= ln_s3;
    end
    if (en[5]) begin
      p7_s5 <= $signed(r_p7[31:0]);
      t1_s5 <= t1_s4;
      t3_s5 <= t3_s4;
      t5_s5 <= $signed(r_t5[33:0]);
      ln_s5 <= ln_s4;
    end
    if (en[6]) begin
      t1_s6 <= t1_s5;
      t3_s6 <= t3_s5;
      t5_s6 <= t5_s5;
      t7_s6 <= $signed(r_t7[33:0]);
      ln_s6 <= ln_s5;
    end
    if (en[7]) begin
      p_s7  <= p_sum[33:0];
      ln_s7 <= ln_s6;
    end
    if (en[8]) begin
      ap_s8 <= $signed(r_ap[33:0]);
      ln_s8 <= ln_s7;
    end
    if (en[9]) begin
      a_s9   <= a_sum;
      pos_s9 <= a_sum > mdl_pkg::THRESH;
      neg_s9 <= a_sum < -mdl_pkg::THRESH;
    end
    if (en[10]) begin
      r_s10 <= r_next;
    end
  end

  assign drive_value = r_s10;

endmodule

`default_nettype wire

FILE: rtl/motor_drive_linearizer.sv
// top level of the motor drive linearizer: stream ports, stage control, checks
//
// channel   dir  fields (tdata, lowest bit up)          width
// s_axis    in   speed_request, signed q1.15              16
// m_axis    out  drive_value, signed q15 scale, 7 pad     24
//
// one request enters per cycle while a stage is free or the output moves on; each result passes through every stage
// the depth is set by the chain of 32x32 multiplies for u^2, u^3, u^5, u^7,
// each followed by its own register, then the blend and the output rounding
// every stage has a valid bit; a stage loads when it is empty or the one
// after it moves on, so bubbles fill while the output waits
// rst clears the valid bits only; data registers carry no reset
`default_nettype none

module motor_drive_linearizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] speed_request
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata    // [16:0] drive_value, [23:17] zero
);

  `include "motor_drive_linearizer_assert.svh"

  localparam int unsigned NS = mdl_pkg::STAGES;

  // valid bit of each stage register
  logic [NS-1:0] vld;
  // stage load enables, rippled back from the output
  logic [NS-1:0] en;
  logic signed [mdl_pkg::OUT_W-1:0] drive_value;

  assign en[NS-1] = !vld[NS-1] || m_axis_tready;

  for (genvar i = 0; i < NS - 1; i++) begin : g_en
    assign en[i] = !vld[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int unsigned k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  mdl_datapath u_datapath (
    .clk           (clk),
    .en            (en),
    .speed_request ($signed(s_axis_tdata)),
    .drive_value   (drive_value)
  );

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld[NS-1];
  assign m_axis_tdata  = {7'd0, drive_value};

  // an empty stage anywhere means a request can be taken
  `MDL_ASSERT_NOW(a_ready_on_bubble, clk, rst, !(&vld), s_axis_tready)
  // a taken request lands in the first stage
  `MDL_ASSERT_NEXT(a_request_lands, clk, rst, s_axis_tvalid && s_axis_tready, vld[0])
  // an item moving out of the second-to-last stage shows up at the output
  `MDL_ASSERT_NEXT(a_reaches_output, clk, rst, vld[NS-2] && en[NS-1], m_axis_tvalid)

endmodule

`default_nettype wire

FILE: dv/motor_drive_linearizer_tb.sv
// self-checking testbench for the motor drive linearizer stream block
`timescale 1ns / 100ps

module motor_drive_linearizer_tb;

  // fixed-point constants of the drive curve, q15 on the input side, q28/q30 inside
  localparam longint REQ_DEADBAND  = 2687;
  localparam longint INV_SPAN      = 1169653403;     // 1/0.918, q30
  localparam longint C1            = 105995498;      // u coefficient, q28
  localparam longint C3            = 180836914;      // u^3 coefficient, q28
  localparam longint C5            = -915273368;     // u^5 coefficient, q28
  localparam longint C7            = 1126657163;     // u^7 coefficient, q28
  localparam longint CURVE_SHARE   = 456340275;      // 0.425, q30
  localparam longint LINE_SHARE    = 147854249;      // 0.15*0.918, q30
  localparam longint SMALL_LIMIT   = 1073742;        // 0.001, q30
  localparam longint DRIVE_OFFSET  = 88046830;       // 0.082, q30
  localparam longint DRIVE_CLAMP   = 34000;

  localparam int ITEMS_PER_PHASE = 400;
  localparam int STALL_LIMIT     = 4000;

  typedef struct {
    logic [15:0]        req;
    bit                 fixed;    // expected drive value typed in below
    logic signed [16:0] drive;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  int sender_idle_pct   = 29;
  int receiver_idle_pct = 62;
  int mismatches = 0;
  int stall_cycles = 0;

  // drive values still owed by the block, oldest first
  logic signed [16:0] pending_drive [$];
  logic signed [16:0] want_drive;

  // deadband edges, small results near the threshold, and both ends of the range
  stim_row_t directed_rows [20] = '{
    '{16'h0000, 1'b1, 17'sd0},
    '{16'h0001, 1'b1, 17'sd0},
    '{16'hffff, 1'b1, 17'sd0},
    '{16'd2687, 1'b1, 17'sd0},
    '{-16'sd2687, 1'b1, 17'sd0},
    '{16'd2688, 1'b0, 17'sd0},
    '{-16'sd2688, 1'b0, 17'sd0},
    '{16'd2750, 1'b0, 17'sd0},
    '{16'd2785, 1'b0, 17'sd0},
    '{-16'sd2785, 1'b0, 17'sd0},
    '{16'd2800, 1'b0, 17'sd0},
    '{16'h4000, 1'b0, 17'sd0},
    '{16'hc000, 1'b0, 17'sd0},
    '{16'h7fff, 1'b0, 17'sd0},
    '{16'h8000, 1'b0, 17'sd0},
    '{16'h7ffe, 1'b0, 17'sd0},
    '{16'h8001, 1'b0, 17'sd0},
    '{16'h5555, 1'b0, 17'sd0},
    '{16'haaaa, 1'b0, 17'sd0},
    '{16'h0000, 1'b1, 17'sd0}
  };

  motor_drive_linearizer u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),    // [15:0] speed_request
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)     // [16:0] drive_value, [23:17] zero
  );

  always #6 clk = ~clk;

  // round half up, then arithmetic shift
  function automatic longint round_down_by(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // linearized drive value for one speed request
  function automatic logic signed [16:0] linearize(input logic [15:0] req);
    longint x, g, u, u2, u3, u5, u7, curve, blend, r;
    x = longint'(signed'(req));
    if (x > REQ_DEADBAND) begin
      g = x - REQ_DEADBAND;
    end else if (x < -REQ_DEADBAND) begin
      g = x + REQ_DEADBAND;
    end else begin
      g = 0;
    end
    // rescale what is left of the request to q30
    u  = round_down_by(g * INV_SPAN, 15);
    u2 = round_down_by(u * u, 30);
    u3 = round_down_by(u2 * u, 30);
    u5 = round_down_by(u3 * u2, 30);
    u7 = round_down_by(u5 * u2, 30);
    curve = round_down_by(C1 * u, 28) + round_down_by(C3 * u3, 28)
          + round_down_by(C5 * u5, 28) + round_down_by(C7 * u7, 28);
    blend = round_down_by(curve * CURVE_SHARE, 30) + round_down_by(u * LINE_SHARE, 30);
    // put the deadband back unless the result is tiny
    if (blend > SMALL_LIMIT) begin
      blend = blend + DRIVE_OFFSET;
    end else if (blend < -SMALL_LIMIT) begin
      blend = blend - DRIVE_OFFSET;
    end
    r = round_down_by(blend, 15);
    if (r > DRIVE_CLAMP) r = DRIVE_CLAMP;
    if (r < -DRIVE_CLAMP) r = -DRIVE_CLAMP;
    return r[16:0];
  endfunction

  // random request, biased toward the deadband edges and full scale
  function automatic logic [15:0] pick_request();
    int k, m;
    k = $urandom_range(99);
    if (k < 55) begin
      return 16'($urandom_range(65535));
    end else if (k < 75) begin
      m = 2647 + $urandom_range(200);
      return $urandom_range(1) ? 16'(m) : 16'(-m);
    end else if (k < 85) begin
      return 16'(int'($urandom_range(5374)) - 2687);
    end else begin
      m = 32767 - $urandom_range(63);
      return $urandom_range(1) ? 16'(m) : 16'(-m - 1);
    end
  endfunction

  // offer one request, with random gaps ahead of it, and note what it must produce
  task automatic send_request(input logic [15:0] req, input bit fixed,
                              input logic signed [16:0] fixed_drive);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_drive.push_back(fixed ? fixed_drive : linearize(req));
  endtask

  // receiver stalls at random, per cycle
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_drive.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: drive_value %0d", $signed(m_axis_tdata[16:0]));
      end else begin
        want_drive = pending_drive.pop_front();
        if (m_axis_tdata[16:0] !== want_drive || m_axis_tdata[23:17] !== 7'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("drive_value mismatch: expected %0d, got %0d (pad %h)",
                     want_drive, $signed(m_axis_tdata[16:0]), m_axis_tdata[23:17]);
        end
      end
    end
  end

  // no handshake on either side for too long means the block hung
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // sender 29% idle, receiver 62% idle for the table and the first random batch
    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].drive);
    for (int n = 0; n < ITEMS_PER_PHASE; n++) send_request(pick_request(), 1'b0, 17'sd0);

    // roles swapped
    sender_idle_pct   = 62;
    receiver_idle_pct = 29;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) send_request(pick_request(), 1'b0, 17'sd0);

    // back to back, no idling on either side
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) send_request(pick_request(), 1'b0, 17'sd0);
    s_axis_tvalid <= 1'b0;

    // drain, then give stray results a chance to show up
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (2 * mdl_pkg::STAGES + 4) @(posedge clk);

    if (mismatches == 0 && pending_drive.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
